/* sv/dmbx_pkg.sv */
package dmbx_pkg;

    // bus access actions
    localparam logic [1:0] ACT_HOST_RD   = 2'd0;
    localparam logic [1:0] ACT_HOST_WR   = 2'd1;
    localparam logic [1:0] ACT_CLIENT_RD = 2'd2;
    localparam logic [1:0] ACT_CLIENT_WR = 2'd3;

    // responses
    localparam logic [1:0] RESP_OK         = 2'd0;
    localparam logic [1:0] RESP_SIZE_ERR   = 2'd1;
    localparam logic [1:0] RESP_DECODE_ERR = 2'd2;

    // memory request codes
    localparam logic [1:0] MEM_NONE = 2'd0;
    localparam logic [1:0] MEM_RD   = 2'd1;
    localparam logic [1:0] MEM_WR   = 2'd2;

    localparam logic [15:0] CAP_ID              = 16'h002E;
    localparam logic [3:0]  CAP_VERSION         = 4'h2;
    localparam logic [31:0] CAP_VALUE           = 32'h0000_2001;
    localparam logic [7:0]  CLIENT_WINDOW_BYTES = 8'h18;
    localparam logic [7:0]  HOST_WINDOW_BYTES   = 8'h24;
    localparam logic [3:0]  HOST_ACCESS_SIZE    = 4'd4;
    localparam logic [31:0] PTR_STEP            = 32'd4;

    // host window register indexes (byte offset / 4)
    localparam logic [5:0] H_CONTROL   = 6'd0;
    localparam logic [5:0] H_STATUS    = 6'd1;
    localparam logic [5:0] H_IN_BASE   = 6'd2;
    localparam logic [5:0] H_IN_LIMIT  = 6'd3;
    localparam logic [5:0] H_IN_WPTR   = 6'd4;
    localparam logic [5:0] H_OUT_BASE  = 6'd5;
    localparam logic [5:0] H_OUT_LIMIT = 6'd6;
    localparam logic [5:0] H_OUT_RPTR  = 6'd7;
    localparam logic [5:0] H_OUT_COUNT = 6'd8;

    // client window register indexes
    localparam logic [5:0] C_CAP_HDR = 6'd0;
    localparam logic [5:0] C_CAP     = 6'd1;
    localparam logic [5:0] C_CONTROL = 6'd2;
    localparam logic [5:0] C_STATUS  = 6'd3;
    localparam logic [5:0] C_WDATA   = 6'd4;
    localparam logic [5:0] C_RDATA   = 6'd5;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  byte_offset;
        logic [3:0]  access_size;
        logic [31:0] write_data;
    } access_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  response;
        logic        data_from_memory;
        logic [1:0]  mem_op;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic        irq_level;
    } result_t;

    // only the live bits of control and status are stored
    typedef struct packed {
        logic async_ie;   // bit 3
        logic int_en;     // bit 1
    } control_t;

    typedef struct packed {
        logic abort;      // bit 31
        logic async_ev;   // bit 3
        logic err;        // bit 2
        logic intr;       // bit 1
        logic busy;       // bit 0
    } status_t;

    function automatic logic [31:0] control_word(control_t c);
        control_word = {28'd0, c.async_ie, 1'b0, c.int_en, 1'b0};
    endfunction

    function automatic logic [31:0] status_word(status_t s);
        status_word = {s.abort, 27'd0, s.async_ev, s.err, s.intr, s.busy};
    endfunction

endpackage

/* sv/dmbx_access_if.sv */
interface dmbx_access_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  byte_offset;
    logic [3:0]  access_size;
    logic [31:0] write_data;

    modport source (output valid, output action, output byte_offset, output access_size,
                    output write_data, input ready);
    modport sink   (input valid, input action, input byte_offset, input access_size,
                    input write_data, output ready);
endinterface

/* sv/dmbx_result_if.sv */
interface dmbx_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [1:0]  response;
    logic        data_from_memory;
    logic [1:0]  mem_op;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;
    logic        irq_level;

    modport source (output valid, output read_data, output response, output data_from_memory,
                    output mem_op, output mem_addr, output mem_wdata, output irq_level,
                    input ready);
    modport sink   (input valid, input read_data, input response, input data_from_memory,
                    input mem_op, input mem_addr, input mem_wdata, input irq_level,
                    output ready);
endinterface

/* sv/dmbx_in_stage.sv */
module dmbx_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  dmbx_pkg::access_t  in_beat,
    output logic               in_ready,
    input  logic               advance,
    output logic               held_valid,
    output dmbx_pkg::access_t  held_beat
);

    logic              valid_reg;
    dmbx_pkg::access_t beat_reg;

    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= in_beat;
        end
    end

endmodule

/* sv/dmbx_exec.sv */
module dmbx_exec (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  dmbx_pkg::access_t  acc,
    input  logic               cfg_wr_en,
    input  logic [11:0]        cfg_wr_data,
    output dmbx_pkg::result_t  res
);

    logic [11:0]        cap_ptr_reg;
    dmbx_pkg::control_t ctl_reg,   ctl_next;
    dmbx_pkg::status_t  st_reg,    st_next;
    logic [29:0]        in_base_reg,   in_base_next;
    logic [29:0]        in_limit_reg,  in_limit_next;
    logic [31:0]        in_wptr_reg,   in_wptr_next;
    logic [29:0]        outbox_base_reg, outbox_base_next;
    logic [29:0]        out_limit_reg, out_limit_next;
    logic [31:0]        out_rptr_reg,  out_rptr_next;
    logic [9:0]         count_reg,     count_next;
    logic               irq_reg,       irq_next;

    logic [5:0]  idx;
    logic [31:0] v;
    logic        count_nz;
    logic [31:0] host_rdata;
    logic [31:0] st_word;

    assign idx      = acc.byte_offset[7:2];
    assign v        = acc.write_data;
    assign count_nz = (count_reg != 10'd0);
    assign st_word  = dmbx_pkg::status_word(st_reg);

    // host window read mux
    always_comb
    begin
        unique case (idx)
            dmbx_pkg::H_CONTROL:   host_rdata = dmbx_pkg::control_word(ctl_reg);
            dmbx_pkg::H_STATUS:    host_rdata = st_word;
            dmbx_pkg::H_IN_BASE:   host_rdata = {in_base_reg, 2'b00};
            dmbx_pkg::H_IN_LIMIT:  host_rdata = {in_limit_reg, 2'b00};
            dmbx_pkg::H_IN_WPTR:   host_rdata = in_wptr_reg;
            dmbx_pkg::H_OUT_BASE:  host_rdata = {outbox_base_reg, 2'b00};
            dmbx_pkg::H_OUT_LIMIT: host_rdata = {out_limit_reg, 2'b00};
            dmbx_pkg::H_OUT_RPTR:  host_rdata = out_rptr_reg;
            dmbx_pkg::H_OUT_COUNT: host_rdata = {22'd0, count_reg};
            default:               host_rdata = 32'd0;
        endcase
    end

    always_comb
    begin
        ctl_next         = ctl_reg;
        st_next          = st_reg;
        in_base_next     = in_base_reg;
        in_limit_next    = in_limit_reg;
        in_wptr_next     = in_wptr_reg;
        outbox_base_next = outbox_base_reg;
        out_limit_next   = out_limit_reg;
        out_rptr_next    = out_rptr_reg;
        count_next       = count_reg;
        irq_next         = irq_reg;

        res.read_data        = 32'd0;
        res.response         = dmbx_pkg::RESP_OK;
        res.data_from_memory = 1'b0;
        res.mem_op           = dmbx_pkg::MEM_NONE;
        res.mem_addr         = 32'd0;
        res.mem_wdata        = 32'd0;

        case (acc.action) inside
            dmbx_pkg::ACT_HOST_RD, dmbx_pkg::ACT_HOST_WR:
            begin
                if (acc.access_size != dmbx_pkg::HOST_ACCESS_SIZE ||
                    acc.byte_offset[1:0] != 2'b00)
                begin
                    res.response = dmbx_pkg::RESP_SIZE_ERR;
                end
                else if (acc.byte_offset >= dmbx_pkg::HOST_WINDOW_BYTES)
                begin
                    res.response = dmbx_pkg::RESP_DECODE_ERR;
                end
                else if (acc.action == dmbx_pkg::ACT_HOST_RD)
                begin
                    res.read_data = host_rdata;
                end
                else
                begin
                    unique case (idx)
                        dmbx_pkg::H_CONTROL:
                        begin
                            ctl_next.async_ie = v[3];
                            ctl_next.int_en   = v[1];
                        end
                        dmbx_pkg::H_STATUS:
                        begin
                            st_next.abort    = v[31];
                            st_next.async_ev = v[3];
                            st_next.err      = v[2];
                            st_next.intr     = v[1];
                            st_next.busy     = v[0];
                            // neither abort nor busy left: interrupt drops
                            if (!v[31] && !v[0])
                            begin
                                irq_next = 1'b0;
                            end
                        end
                        dmbx_pkg::H_IN_BASE:   in_base_next     = v[31:2];
                        dmbx_pkg::H_IN_LIMIT:  in_limit_next    = v[31:2];
                        dmbx_pkg::H_IN_WPTR:   in_wptr_next     = v;
                        dmbx_pkg::H_OUT_BASE:  outbox_base_next = v[31:2];
                        dmbx_pkg::H_OUT_LIMIT: out_limit_next   = v[31:2];
                        dmbx_pkg::H_OUT_RPTR:  out_rptr_next    = v;
                        dmbx_pkg::H_OUT_COUNT: count_next       = v[9:0];
                        default:               ;
                    endcase
                end
            end

            default:
            begin
                if (acc.byte_offset >= dmbx_pkg::CLIENT_WINDOW_BYTES)
                begin
                    res.response = dmbx_pkg::RESP_DECODE_ERR;
                end
                else if (acc.action == dmbx_pkg::ACT_CLIENT_RD)
                begin
                    unique case (idx)
                        dmbx_pkg::C_CAP_HDR:
                            res.read_data = {cap_ptr_reg, dmbx_pkg::CAP_VERSION,
                                             dmbx_pkg::CAP_ID};
                        dmbx_pkg::C_CAP:
                            res.read_data = dmbx_pkg::CAP_VALUE;
                        dmbx_pkg::C_CONTROL:
                            res.read_data = dmbx_pkg::control_word(ctl_reg);
                        dmbx_pkg::C_STATUS:
                            res.read_data = {count_nz, st_word[30:0]};
                        dmbx_pkg::C_RDATA:
                        begin
                            if (count_nz)
                            begin
                                res.data_from_memory = 1'b1;
                                res.mem_op           = dmbx_pkg::MEM_RD;
                                res.mem_addr         = out_rptr_reg;
                            end
                        end
                        default: ;
                    endcase
                end
                else
                begin
                    unique case (idx)
                        dmbx_pkg::C_CONTROL:
                        begin
                            if (v[0])
                            begin
                                in_wptr_next = {in_base_reg, 2'b00};
                                if (st_reg.busy || st_reg.err || count_nz)
                                begin
                                    st_next.abort = 1'b1;
                                    irq_next      = 1'b1;
                                end
                            end
                            else if (v[31] && !st_reg.abort && !st_reg.busy && !st_reg.err)
                            begin
                                st_next.busy = 1'b1;
                                irq_next     = 1'b1;
                            end
                            ctl_next.async_ie = ctl_reg.async_ie | v[3];
                            ctl_next.int_en   = ctl_reg.int_en | v[1];
                        end
                        dmbx_pkg::C_STATUS:
                        begin
                            st_next.intr     = st_reg.intr & ~v[1];
                            st_next.async_ev = st_reg.async_ev & ~v[3];
                        end
                        dmbx_pkg::C_WDATA:
                        begin
                            if (!st_reg.busy && in_wptr_reg < {in_limit_reg, 2'b00})
                            begin
                                res.mem_op    = dmbx_pkg::MEM_WR;
                                res.mem_addr  = in_wptr_reg;
                                res.mem_wdata = v;
                                in_wptr_next  = in_wptr_reg + dmbx_pkg::PTR_STEP;
                            end
                        end
                        dmbx_pkg::C_RDATA:
                        begin
                            if (count_nz)
                            begin
                                out_rptr_next = out_rptr_reg + dmbx_pkg::PTR_STEP;
                                count_next    = count_reg - 10'd1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        endcase

        res.irq_level = irq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_ptr_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            cap_ptr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg         <= '0;
            st_reg          <= '0;
            in_base_reg     <= '0;
            in_limit_reg    <= '0;
            in_wptr_reg     <= '0;
            outbox_base_reg <= '0;
            out_limit_reg   <= '0;
            out_rptr_reg    <= '0;
            count_reg       <= '0;
            irq_reg         <= 1'b0;
        end
        else if (fire)
        begin
            ctl_reg         <= ctl_next;
            st_reg          <= st_next;
            in_base_reg     <= in_base_next;
            in_limit_reg    <= in_limit_next;
            in_wptr_reg     <= in_wptr_next;
            outbox_base_reg <= outbox_base_next;
            out_limit_reg   <= out_limit_next;
            out_rptr_reg    <= out_rptr_next;
            count_reg       <= count_next;
            irq_reg         <= irq_next;
        end
    end

endmodule

/* sv/dmbx_out_stage.sv */
module dmbx_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  dmbx_pkg::result_t  res_in,
    output logic               can_load,
    output logic               out_valid,
    input  logic               out_ready,
    output dmbx_pkg::result_t  res_out
);

    logic              valid_reg;
    dmbx_pkg::result_t res_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

/* sv/doe_mailbox_registers_core.sv */
// Mailbox register block for data object exchange. Each beat on bus is one
// 32-bit register access, on the host window (action 0 read, 1 write) or the
// client window (2 read, 3 write), and yields exactly one beat on reply with
// the read data, response code, any memory request for mailbox data and the
// host interrupt level after the access. Accesses flow through an input
// register, one pass of decode and update logic, and an output register: one
// beat per clock is sustained while reply is not stalled, and reply is driven
// straight from the output register. Register state is updated as the beat
// leaves the input register, so back-to-back accesses always see the effect
// of the one before. A stalled reply holds both registers; bus.ready falls
// only when both are full. cfg_wr_en/cfg_wr_data set the next capability
// pointer shown in the client capability header; write it only while idle.
module doe_mailbox_registers_core (
    input  logic                 clk,
    input  logic                 rst_n,
    dmbx_access_if.sink          bus,
    dmbx_result_if.source        reply,
    input  logic                 cfg_wr_en,
    input  logic [11:0]          cfg_wr_data
);

    dmbx_pkg::access_t in_beat;
    dmbx_pkg::access_t held_beat;
    dmbx_pkg::result_t exec_res;
    dmbx_pkg::result_t out_res;
    logic              held_valid;
    logic              can_load;
    logic              fire;

    assign in_beat.action      = bus.action;
    assign in_beat.byte_offset = bus.byte_offset;
    assign in_beat.access_size = bus.access_size;
    assign in_beat.write_data  = bus.write_data;

    // an access is executed when it sits in the input register and the
    // output register is free or being drained this cycle
    assign fire = held_valid && can_load;

    dmbx_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (bus.valid),
        .in_beat    (in_beat),
        .in_ready   (bus.ready),
        .advance    (can_load),
        .held_valid (held_valid),
        .held_beat  (held_beat)
    );

    dmbx_exec u_exec (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .acc         (held_beat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res         (exec_res)
    );

    dmbx_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .res_in    (exec_res),
        .can_load  (can_load),
        .out_valid (reply.valid),
        .out_ready (reply.ready),
        .res_out   (out_res)
    );

    assign reply.read_data        = out_res.read_data;
    assign reply.response         = out_res.response;
    assign reply.data_from_memory = out_res.data_from_memory;
    assign reply.mem_op           = out_res.mem_op;
    assign reply.mem_addr         = out_res.mem_addr;
    assign reply.mem_wdata        = out_res.mem_wdata;
    assign reply.irq_level        = out_res.irq_level;

endmodule
